// ----- rtl/fp16_hard_swish_core_defines.svh -----
// Assertion macros for the hard-swish block
`ifndef FP16_HARD_SWISH_CORE_DEFINES_SVH
`define FP16_HARD_SWISH_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HSW_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define HSW_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define HSW_ASSERT(label, clk, rst, prop)
`define HSW_ASSERT_RST(label, clk, prop)
`endif
`endif

// ----- rtl/hsw_pkg.sv -----
package hsw_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] QNAN       = 16'h7E00;
  localparam logic [15:0] RESET_CLIP = 16'h4600;
  localparam logic [15:0] RESET_ISCL = 16'h3155;
  localparam logic [15:0] RESET_OFFS = 16'h4200;

  localparam logic [1:0] REG_CLIP = 2'd0;
  localparam logic [1:0] REG_ISCL = 2'd1;
  localparam logic [1:0] REG_OFFS = 2'd2;

  // item after the front end: clamped shifted value and the raw input
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] t;
    logic        eot;
  } front_item_t;

  typedef struct packed {
    logic [15:0] y;
    logic        eot;
  } result_t;

  function automatic logic is_nan(input logic [15:0] h);
    return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
  endfunction

  function automatic logic is_inf(input logic [15:0] h);
    return h[14:0] == 15'h7C00;
  endfunction

  function automatic logic is_zero(input logic [15:0] h);
    return h[14:0] == 15'd0;
  endfunction

  function automatic logic [10:0] sig_of(input logic [15:0] h);
    return (h[14:10] == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
  endfunction

  // biased exponent with subnormals at 1
  function automatic logic [4:0] exp_of(input logic [15:0] h);
    return (h[14:10] == 5'd0) ? 5'd1 : h[14:10];
  endfunction

  function automatic logic [5:0] lzc24(input logic [23:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(23 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Round sign * m * 2^(e-25) where m is 24 bits, e biased-like (signed).
  // Value = m * 2^(e - 25) on the add path, with e the smaller exponent; here the
  // common form: m in [0,2^24), value = m * 2^(ebase), ebase signed.
  function automatic logic [15:0] pack(input logic s, input logic [23:0] m,
                                       input logic signed [8:0] ebase);
    logic [5:0]         lz;
    logic [23:0]        nm;
    logic signed [9:0]  ef;
    logic signed [9:0]  sh;
    logic [47:0]        ext;
    logic [10:0]        mm;
    logic               g, st;
    logic [11:0]        r;
    logic [15:0]        res;
    // nm has msb at bit 23; value = nm * 2^(ebase - lz); mantissa 11 bits
    // at bits 23:13, biased exponent = ebase - lz + 23 + 15
    lz  = lzc24(m);
    nm  = m << lz;
    ef  = 10'(ebase) - 10'(lz) + 10'sd38;
    sh  = 10'sd0;
    if (ef < 10'sd1) begin
      sh = 10'sd1 - ef;
      ef = 10'sd1;
    end
    if (sh > 10'sd30) sh = 10'sd30;
    ext = {nm, 24'd0} >> sh[4:0];
    mm  = ext[47:37];
    g   = ext[36];
    st  = |ext[35:0];
    r   = {1'b0, mm} + 12'((g && (st || mm[0])) ? 1 : 0);
    if (r[11]) begin
      r  = 12'h400;
      ef = ef + 10'sd1;
    end
    if (m == 24'd0 || r == 12'd0) res = {s, 15'd0};
    else if (!r[10]) res = {s, 5'd0, r[9:0]};
    else if (ef >= 10'sd31) res = {s, 15'h7C00};
    else res = {s, ef[4:0], r[9:0]};
    return res;
  endfunction

endpackage

// ----- rtl/hsw_stream_if.sv -----
interface hsw_stream_if #(parameter int unsigned W = 17);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/hsw_cfg_if.sv -----
interface hsw_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/hsw_front.sv -----
// x + offset, clamped to [0, threshold]; registered output stage
module hsw_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [15:0]               x,
  input  logic                      eot,
  input  logic [15:0]               offs,
  input  logic [15:0]               clip,
  output logic                      out_valid,
  input  logic                      out_ready,
  output hsw_pkg::front_item_t      out_item
);
  logic [15:0] sum, t0, t1;
  logic [4:0]  ea, eb, emin;
  logic [23:0] va, vb, mag;
  logic signed [25:0] sv;

  always_comb begin
    ea = hsw_pkg::exp_of(x);
    eb = hsw_pkg::exp_of(offs);
    emin = (ea < eb) ? ea : eb;
    // cap keeps the aligned value in 24 bits; a gap above 13 puts the smaller
    // operand below a quarter ulp of the larger, so the larger is the sum
    va = 24'(hsw_pkg::sig_of(x)) << ((ea - emin > 5'd13) ? 5'd13 : (ea - emin));
    vb = 24'(hsw_pkg::sig_of(offs)) << ((eb - emin > 5'd13) ? 5'd13 : (eb - emin));
    sv = (x[15] ? -$signed({2'b0, va}) : $signed({2'b0, va})) +
         (offs[15] ? -$signed({2'b0, vb}) : $signed({2'b0, vb}));
    mag = sv[25] ? 24'(-sv) : 24'(sv);
    if (hsw_pkg::is_nan(x) || hsw_pkg::is_nan(offs)) sum = hsw_pkg::QNAN;
    else if (hsw_pkg::is_inf(x) && hsw_pkg::is_inf(offs))
      sum = (x[15] == offs[15]) ? x : hsw_pkg::QNAN;
    else if (hsw_pkg::is_inf(x)) sum = x;
    else if (hsw_pkg::is_inf(offs)) sum = offs;
    else if (ea - emin > 5'd13) sum = x;
    else if (eb - emin > 5'd13) sum = offs;
    else if (sv == 26'sd0) sum = {x[15] & offs[15], 15'd0};
    else sum = hsw_pkg::pack(sv[25], mag, 9'($signed({4'd0, emin})) - 9'sd25);
    // max(+0, sum)
    if (hsw_pkg::is_nan(sum)) t0 = hsw_pkg::QNAN;
    else if (hsw_pkg::is_zero(sum)) t0 = 16'd0;
    else t0 = sum[15] ? 16'd0 : sum;
    // min(clip, t0); t0 is non-negative here
    if (hsw_pkg::is_nan(clip) || hsw_pkg::is_nan(t0)) t1 = hsw_pkg::QNAN;
    else if (hsw_pkg::is_zero(clip) && hsw_pkg::is_zero(t0)) t1 = clip | t0;
    else if (clip[15]) t1 = clip;
    else t1 = (clip[14:0] <= t0[14:0]) ? clip : t0;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_item <= '{x: x, t: t1, eot: eot};
    end
  end
endmodule

// ----- rtl/hsw_queue.sv -----
// small FIFO between front and back
module hsw_queue #(
  parameter int unsigned DEPTH = hsw_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsw_pkg::front_item_t in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hsw_pkg::front_item_t out_item
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  hsw_pkg::front_item_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic          push, pop;

  assign in_ready  = cnt != (AW+1)'(DEPTH);
  assign out_valid = cnt != '0;
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;
  assign out_item = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem[wp] <= in_item;
  end
endmodule

// ----- rtl/hsw_back.sv -----
// two multiplies: s = iscl*x, r = s*t; two stages with registers between
module hsw_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsw_pkg::front_item_t in_item,
  input  logic [15:0]          iscl,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hsw_pkg::result_t     out_res
);
  function automatic logic [15:0] fmul(input logic [15:0] a, input logic [15:0] b);
    logic        s;
    logic [21:0] p;
    logic signed [8:0] e;
    s = a[15] ^ b[15];
    p = hsw_pkg::sig_of(a) * hsw_pkg::sig_of(b);
    // value = p * 2^(ea+eb-50); pack wants m*2^ebase
    e = 9'($signed({4'd0, hsw_pkg::exp_of(a)})) +
        9'($signed({4'd0, hsw_pkg::exp_of(b)})) - 9'sd50;
    if (hsw_pkg::is_nan(a) || hsw_pkg::is_nan(b)) return hsw_pkg::QNAN;
    if (hsw_pkg::is_inf(a) || hsw_pkg::is_inf(b)) begin
      if (hsw_pkg::is_zero(a) || hsw_pkg::is_zero(b)) return hsw_pkg::QNAN;
      return {s, 15'h7C00};
    end
    return hsw_pkg::pack(s, {2'b0, p}, e);
  endfunction

  logic        v1;
  logic [15:0] s1, t1;
  logic        e1;
  logic        adv1, adv2;

  assign adv2 = !out_valid || out_ready;
  assign adv1 = !v1 || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) out_valid <= v1;
    end
    if (adv1 && in_valid) begin
      s1 <= fmul(iscl, in_item.x);
      t1 <= in_item.t;
      e1 <= in_item.eot;
    end
    if (adv2 && v1) begin
      out_res <= '{y: fmul(s1, t1), eot: e1};
    end
  end
endmodule

// ----- rtl/fp16_hard_swish_core.sv -----
// fp16 hard swish: y = min(clip, max(0, x + offset)) * (inverse_scale * x)
// Channels:
//   in  : hsw_stream_if, data = {x_half, end_of_tensor_in}
//   out : hsw_stream_if, data = {y_half, end_of_tensor_out}
//   cfg : index 0 clip_threshold, 1 inverse_scale, 2 shift_offset; other
//         indexes are dropped. Always ready.
// Path from input transaction to result valid: front register, queue,
// multiply stage, output register.
// Throughput: one transaction per cycle while the receiver keeps up, set by the
// combinational add/clamp in the front and the two pipelined multiply stages in the back.
// Reset (rst, synchronous): all pipeline valids and the queue empty,
// registers return to 6.0, 1/6 and 3.0.
// Receiver stall: the output register holds, the back pipeline fills, then
// the queue, then the front stops taking transactions; nothing is dropped.
`include "fp16_hard_swish_core_defines.svh"
module fp16_hard_swish_core #(
  parameter int unsigned QUEUE_DEPTH = hsw_pkg::QueueDepth
) (
  input logic          clk,
  input logic          rst,
  hsw_stream_if.sink   in_ch,
  hsw_stream_if.source out_ch,
  hsw_cfg_if.sink      cfg
);
  logic [15:0] clip, iscl, offs;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      clip <= hsw_pkg::RESET_CLIP;
      iscl <= hsw_pkg::RESET_ISCL;
      offs <= hsw_pkg::RESET_OFFS;
    end else if (cfg.valid) begin
      case (cfg.index)
        hsw_pkg::REG_CLIP: clip <= cfg.data;
        hsw_pkg::REG_ISCL: iscl <= cfg.data;
        hsw_pkg::REG_OFFS: offs <= cfg.data;
        default: ;
      endcase
    end
  end

  logic                 f_valid, f_ready, q_valid, q_ready, b_valid;
  hsw_pkg::front_item_t f_item, q_item;
  hsw_pkg::result_t     b_res;

  hsw_front u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .x(in_ch.data[16:1]), .eot(in_ch.data[0]),
    .offs, .clip,
    .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
  );

  hsw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  hsw_back u_back (
    .clk, .rst,
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item), .iscl,
    .out_valid(b_valid), .out_ready(out_ch.ready), .out_res(b_res)
  );

  assign out_ch.valid = b_valid;
  assign out_ch.data  = {b_res.y, b_res.eot};

  // a stalled result holds its data
  `HSW_ASSERT(a_out_hold, clk, rst,
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
  // any NaN result is the canonical quiet NaN
  `HSW_ASSERT(a_qnan, clk, rst,
    (out_ch.valid && out_ch.data[15:11] == 5'h1F && out_ch.data[10:1] != 10'd0)
      |-> (out_ch.data[16:1] == hsw_pkg::QNAN))
  // reset empties the pipeline
  `HSW_ASSERT_RST(a_rst_empty, clk, rst |=> !out_ch.valid)
endmodule

// ----- tb/tb_top.sv -----
module tb_top;

  // register index with no register behind it: writes must be dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned N_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned N_DIRECTED = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  hsw_stream_if #(.W(17)) in_ch ();
  hsw_stream_if #(.W(17)) out_ch ();
  hsw_cfg_if cfg_ch ();

  fp16_hard_swish_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  // one expected result per accepted input transaction
  typedef struct packed {
    logic [15:0] y;
    logic        eot;
  } swish_out_t;

  // directed row: typed result only where it is obvious under reset settings
  typedef struct {
    logic [15:0] x;
    logic        eot;
    bit          typed;
    logic [15:0] y;
  } swish_row_t;

  swish_out_t  swish_pending[$];
  int unsigned n_errors = 0;
  int unsigned cycle_cnt = 0;
  bit          no_gaps = 1'b0;   // shared burst mode: both sides stop idling
  bit          hold_out = 1'b0;  // request for a long receiver stall

  // shadow copies of the three registers
  logic [15:0] clip_reg, iscl_reg, offs_reg;

  // ---------------------------------------------------------------------
  // binary16 arithmetic, nearest-even, subnormals kept, NaN -> QNAN
  // ---------------------------------------------------------------------
  function automatic bit h_is_nan(input logic [15:0] h);
    return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
  endfunction

  function automatic bit h_is_inf(input logic [15:0] h);
    return h[14:0] == 15'h7C00;
  endfunction

  function automatic bit h_is_zero(input logic [15:0] h);
    return h[14:0] == 15'd0;
  endfunction

  // value = m * 2^e
  function automatic void h_unpack(input logic [15:0] h, output longint unsigned m,
                                   output int e);
    if (h[14:10] == 5'd0) begin
      m = longint'(h[9:0]);
      e = -24;
    end else begin
      m = longint'({1'b1, h[9:0]});
      e = int'(h[14:10]) - 25;
    end
  endfunction

  function automatic logic [15:0] h_round(input logic s, input longint unsigned m,
                                          input int e);
    int len, q, sh;
    longint unsigned t, mm, rem, half;
    if (m == 0) return {s, 15'd0};
    len = 0;
    t = m;
    while (t != 0) begin
      len++;
      t = t >> 1;
    end
    q = len - 1 + e - 10;
    if (q < -24) q = -24;
    if (q > e) begin
      sh = q - e;
      if (sh > 62) begin
        mm = 0;
      end else begin
        rem  = m & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        mm   = m >> sh;
        if (rem > half || (rem == half && (mm & 1) != 0)) mm++;
      end
    end else begin
      mm = m << (e - q);
    end
    if (mm == 2048) begin
      mm = 1024;
      q++;
    end
    if (mm == 0) return {s, 15'd0};
    if (mm >= 1024) begin
      if (q + 25 >= 31) return {s, 15'h7C00};
      return {s, 5'(q + 25), mm[9:0]};
    end
    return {s, 5'd0, mm[9:0]};
  endfunction

  function automatic logic [15:0] h_sum(input logic [15:0] a, input logic [15:0] b);
    longint unsigned ma, mb;
    int ea, eb, e;
    longint va, vb, acc;
    if (h_is_nan(a) || h_is_nan(b)) return hsw_pkg::QNAN;
    if (h_is_inf(a) && h_is_inf(b)) return (a[15] == b[15]) ? a : hsw_pkg::QNAN;
    if (h_is_inf(a)) return a;
    if (h_is_inf(b)) return b;
    h_unpack(a, ma, ea);
    h_unpack(b, mb, eb);
    e  = (ea < eb) ? ea : eb;
    va = longint'(ma << (ea - e));
    vb = longint'(mb << (eb - e));
    if (a[15]) va = -va;
    if (b[15]) vb = -vb;
    acc = va + vb;
    if (acc == 0) return (a[15] && b[15]) ? 16'h8000 : 16'h0000;
    if (acc < 0) return h_round(1'b1, longint'(-acc), e);
    return h_round(1'b0, longint'(acc), e);
  endfunction

  function automatic logic [15:0] h_prod(input logic [15:0] a, input logic [15:0] b);
    longint unsigned ma, mb;
    int ea, eb;
    logic s;
    s = a[15] ^ b[15];
    if (h_is_nan(a) || h_is_nan(b)) return hsw_pkg::QNAN;
    if (h_is_inf(a) || h_is_inf(b)) begin
      if (h_is_zero(a) || h_is_zero(b)) return hsw_pkg::QNAN;
      return {s, 15'h7C00};
    end
    h_unpack(a, ma, ea);
    h_unpack(b, mb, eb);
    return h_round(s, ma * mb, ea + eb);
  endfunction

  // signed ordering key, both zeros share 0
  function automatic int h_order(input logic [15:0] h);
    return h[15] ? -int'(h[14:0]) : int'(h[14:0]);
  endfunction

  function automatic logic [15:0] h_larger(input logic [15:0] a, input logic [15:0] b);
    if (h_is_nan(a) || h_is_nan(b)) return hsw_pkg::QNAN;
    if (h_is_zero(a) && h_is_zero(b)) return a & b;
    return (h_order(a) >= h_order(b)) ? a : b;
  endfunction

  function automatic logic [15:0] h_smaller(input logic [15:0] a, input logic [15:0] b);
    if (h_is_nan(a) || h_is_nan(b)) return hsw_pkg::QNAN;
    if (h_is_zero(a) && h_is_zero(b)) return a | b;
    return (h_order(a) <= h_order(b)) ? a : b;
  endfunction

  // the activation itself, using the current shadow registers
  function automatic logic [15:0] hard_swish(input logic [15:0] x);
    logic [15:0] gate, scaled, y;
    gate   = h_smaller(clip_reg, h_larger(16'h0000, h_sum(x, offs_reg)));
    scaled = h_prod(iscl_reg, x);
    y      = h_prod(scaled, gate);
    if (h_is_nan(y)) y = hsw_pkg::QNAN;
    return y;
  endfunction

  // operands weighted towards the interesting corners of the format
  function automatic logic [15:0] pick_half();
    logic [15:0] h;
    case ($urandom_range(0, 5))
      0: h = {$urandom_range(0, 1) == 1, 5'($urandom_range(10, 19)), 10'($urandom)};
      1: h = {$urandom_range(0, 1) == 1, 5'd0, 10'($urandom)};
      2: h = {$urandom_range(0, 1) == 1, 5'($urandom_range(28, 31)), 10'($urandom)};
      3: begin
        case ($urandom_range(0, 5))
          0: h = 16'h7C00;
          1: h = 16'hFC00;
          2: h = 16'h0000;
          3: h = 16'h8000;
          4: h = 16'h7BFF;
          default: h = 16'hFBFF;
        endcase
      end
      default: h = 16'($urandom);
    endcase
    return h;
  endfunction

  task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
    $display("mismatch %s: expected %h got %h (cycle %0d)", what, want, got, cycle_cnt);
    n_errors++;
  endtask

  // one input transaction; the expectation is queued as it is accepted
  task automatic send_item(input logic [15:0] x, input logic eot, input bit typed,
                           input logic [15:0] y_typed);
    int unsigned gap;
    swish_out_t expd;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= {x, eot};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expd.y   = typed ? y_typed : hard_swish(x);
    expd.eot = eot;
    swish_pending.push_back(expd);
  endtask

  // valid stays high between back-to-back writes; the caller drops it
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      hsw_pkg::REG_CLIP: clip_reg = value;
      hsw_pkg::REG_ISCL: iscl_reg = value;
      hsw_pkg::REG_OFFS: offs_reg = value;
      default: ;
    endcase
  endtask

  // drain: wait until nothing is pending, then let the pipe go quiet
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (swish_pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  swish_row_t directed_rows[N_DIRECTED] = '{
    '{16'h0000, 1'b0, 1'b1, 16'h0000},   // zero in, zero out
    '{16'h7C00, 1'b1, 1'b1, 16'h7C00},   // +inf: gate clamps to 6, inf * 6
    '{16'hFC00, 1'b0, 1'b1, 16'h7E00},   // -inf: gate is 0, inf * 0 invalid
    '{16'h7C01, 1'b1, 1'b1, 16'h7E00},   // signalling NaN in
    '{16'hFE00, 1'b0, 1'b1, 16'h7E00},   // negative quiet NaN in
    '{16'hFFFF, 1'b1, 1'b1, 16'h7E00},   // all ones
    '{16'h8000, 1'b0, 1'b0, 16'h0000},   // negative zero
    '{16'h0001, 1'b1, 1'b0, 16'h0000},   // smallest subnormal
    '{16'h8001, 1'b0, 1'b0, 16'h0000},
    '{16'h03FF, 1'b0, 1'b0, 16'h0000},   // largest subnormal
    '{16'h83FF, 1'b1, 1'b0, 16'h0000},
    '{16'h0400, 1'b0, 1'b0, 16'h0000},   // smallest normal
    '{16'h7BFF, 1'b1, 1'b0, 16'h0000},   // largest finite, may overflow
    '{16'hFBFF, 1'b0, 1'b0, 16'h0000},
    '{16'h4200, 1'b0, 1'b0, 16'h0000},   // 3.0
    '{16'hC200, 1'b1, 1'b0, 16'h0000},   // -3.0, shifted sum exactly zero
    '{16'hC600, 1'b0, 1'b0, 16'h0000},   // -6.0
    '{16'h4600, 1'b0, 1'b0, 16'h0000},   // 6.0
    '{16'hBC00, 1'b1, 1'b0, 16'h0000},   // -1.0
    '{16'h3C00, 1'b0, 1'b0, 16'h0000}    // 1.0
  };

  // cycle count and timeout guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("** fp16_hard_swish_core: FAILED **");
      $finish;
    end
  end

  // result checker: oldest expectation against each accepted result
  always @(posedge clk) begin
    swish_out_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (swish_pending.size() == 0) begin
        report("unexpected result", 16'h0000, out_ch.data[16:1]);
      end else begin
        want = swish_pending.pop_front();
        if (out_ch.data[16:1] !== want.y) report("y_half", want.y, out_ch.data[16:1]);
        if (out_ch.data[0] !== want.eot) report("end_of_tensor", 16'(want.eot),
                                                16'(out_ch.data[0]));
      end
    end
  end

  // receiver: random hold-offs, burst stretches, one long stall on request
  initial begin
    int unsigned gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // main sequence
  initial begin
    logic [15:0] cfg_set[3];
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= hsw_pkg::REG_CLIP;
    cfg_ch.data  <= '0;
    clip_reg = hsw_pkg::RESET_CLIP;
    iscl_reg = hsw_pkg::RESET_ISCL;
    offs_reg = hsw_pkg::RESET_OFFS;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows under reset settings
    foreach (directed_rows[i])
      send_item(directed_rows[i].x, directed_rows[i].eot, directed_rows[i].typed,
                directed_rows[i].y);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: cfg_set = '{hsw_pkg::RESET_CLIP, hsw_pkg::RESET_ISCL, hsw_pkg::RESET_OFFS};
        1: cfg_set = '{16'h0000, 16'h0000, 16'h0000};
        2: cfg_set = '{16'hFFFF, 16'hFFFF, 16'hFFFF};     // NaN everywhere
        3: cfg_set = '{16'h7C00, 16'hFC00, 16'h7C00};     // infinities
        4: cfg_set = '{16'h8000, 16'h7BFF, 16'hFBFF};
        5: cfg_set = '{16'h0001, 16'h83FF, 16'h8000};     // subnormals, -0 offset
        default: cfg_set = '{16'($urandom), 16'($urandom), 16'($urandom)};
      endcase
      write_reg(hsw_pkg::REG_CLIP, cfg_set[0]);
      write_reg(hsw_pkg::REG_ISCL, cfg_set[1]);
      write_reg(hsw_pkg::REG_OFFS, cfg_set[2]);
      // ignored index, data that would be visible if it landed anywhere
      if (ph % 2 == 1) write_reg(REG_UNUSED, 16'h7E00);
      cfg_ch.valid <= 1'b0;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        // long output stall while the sender keeps pushing
        if (ph == 0 && k == 60) begin
          hold_out = 1'b1;
          no_gaps = 1'b1;
        end
        send_item(pick_half(), 1'($urandom_range(0, 1)), 1'b0, 16'h0000);
      end
      no_gaps = 1'b0;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("** fp16_hard_swish_core: PASSED **");
    end else begin
      $display("** fp16_hard_swish_core: FAILED **");
    end
    $finish;
  end

endmodule
